// ----- design/json_string_unescape_assert.svh -----
// ----------------------------------------------------------------------------
// json_string_unescape assertion macros
// shared property forms for the unescaper checks, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("jsu check failed: same-cycle implication");

// next-cycle implication
`define JSU_ASSERT_NXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("jsu check failed: next-cycle implication");

`endif

// ----- design/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helper functions shared by the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int JSU_CMD_DEPTH = 4;

	// parser phase
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_STR     = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX1    = 4'd3,
		PH_WANT_BS = 4'd4,
		PH_WANT_U  = 4'd5,
		PH_HEX2    = 4'd6
	} phase_t;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		K_RAW  = 2'd0,
		K_CP   = 2'd1,
		K_DONE = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [20:0] cp;
	} cmd_t;

	// result outcome codes
	localparam logic [1:0] OC_BYTE = 2'd0;
	localparam logic [1:0] OC_DONE = 2'd1;
	localparam logic [1:0] OC_ERR  = 2'd2;

	// characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [15:0] HI_SUR_LO = 16'hD800;
	localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SUR_LO = 16'hDC00;
	localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [20:0] MAX_1BYTE = 21'h7F;
	localparam logic [20:0] MAX_2BYTE = 21'h7FF;
	localparam logic [20:0] MAX_3BYTE = 21'hFFFF;

	// hex digit value, bit 4 set when not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			r = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			r = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46)
			r = 5'(c - 8'h37);
		return r;
	endfunction

	// simple escape letter: bit 8 = recognised, low byte = decoded char
	function automatic logic [8:0] esc_decode(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SLASH:  r = {1'b1, CH_SLASH};
			CH_B:      r = {1'b1, 8'h08};
			CH_F:      r = {1'b1, 8'h0C};
			CH_N:      r = {1'b1, 8'h0A};
			CH_R:      r = {1'b1, 8'h0D};
			CH_T:      r = {1'b1, 8'h09};
			default:   r = 9'h000;
		endcase
		return r;
	endfunction

	// utf-8 length minus one
	function automatic logic [1:0] utf8_lm1(input logic [20:0] cp);
		logic [1:0] r;
		if (cp <= MAX_1BYTE)
			r = 2'd0;
		else if (cp <= MAX_2BYTE)
			r = 2'd1;
		else if (cp <= MAX_3BYTE)
			r = 2'd2;
		else
			r = 2'd3;
		return r;
	endfunction

	// byte idx of the utf-8 form of cp
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] r;
		logic [1:0] lm1;
		lm1 = utf8_lm1(cp);
		r = cp[7:0];
		unique case ({lm1, idx})
			4'b00_00: r = cp[7:0];
			4'b01_00: r = {3'b110, cp[10:6]};
			4'b01_01: r = {2'b10, cp[5:0]};
			4'b10_00: r = {4'b1110, cp[15:12]};
			4'b10_01: r = {2'b10, cp[11:6]};
			4'b10_10: r = {2'b10, cp[5:0]};
			4'b11_00: r = {5'b11110, cp[20:18]};
			4'b11_01: r = {2'b10, cp[17:12]};
			4'b11_10: r = {2'b10, cp[11:6]};
			4'b11_11: r = {2'b10, cp[5:0]};
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- design/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// string parser: takes one source byte per cycle while the command queue is not full, issues decode commands
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    in_byte,
	input  logic          source_end,
	input  logic          cmd_full,
	output logic          cmd_push,
	output jsu_pkg::cmd_t cmd
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  hh_q, hh_d;

	logic        accept;
	logic [4:0]  hv;
	logic [8:0]  esc;
	logic [15:0] acc_sh;
	logic        is_quote, is_bs, is_u, is_ctrl, hex_ok, last_dig, is_high, is_low;
	logic [20:0] supp_cp;

	assign accept   = push && !cmd_full;
	assign hv       = hex_val(in_byte);
	assign esc      = esc_decode(in_byte);
	assign acc_sh   = {acc_q[11:0], hv[3:0]};
	assign is_quote = (in_byte == CH_QUOTE);
	assign is_bs    = (in_byte == CH_BSLASH);
	assign is_u     = (in_byte == CH_U);
	assign is_ctrl  = (in_byte < CH_SPACE);
	assign hex_ok   = !hv[4];
	assign last_dig = (cnt_q == 2'd3);
	assign is_high  = (acc_sh >= HI_SUR_LO) && (acc_sh <= HI_SUR_HI);
	assign is_low   = (acc_sh >= LO_SUR_LO) && (acc_sh <= LO_SUR_HI);
	assign supp_cp  = {1'b0, hh_q, acc_sh[9:0]} + SUPP_BASE;

	// next state
	always_comb begin
		logic fail;
		fail    = 1'b0;
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		hh_d    = hh_q;
		if (accept) begin
			if (source_end) begin
				fail = (phase_q != PH_IDLE);
			end else begin
				unique case (phase_q)
					PH_STR: begin
						if (is_quote)
							phase_d = PH_IDLE;
						else if (is_ctrl)
							fail = 1'b1;
						else if (is_bs)
							phase_d = PH_ESC;
					end
					PH_ESC: begin
						if (esc[8]) begin
							phase_d = PH_STR;
						end else if (is_u) begin
							phase_d = PH_HEX1;
							acc_d   = '0;
							cnt_d   = '0;
						end else begin
							fail = 1'b1;
						end
					end
					PH_WANT_BS: begin
						if (is_bs)
							phase_d = PH_WANT_U;
						else
							fail = 1'b1;
					end
					PH_WANT_U: begin
						if (is_u) begin
							phase_d = PH_HEX2;
							acc_d   = '0;
							cnt_d   = '0;
						end else begin
							fail = 1'b1;
						end
					end
					PH_HEX1, PH_HEX2: begin
						if (!hex_ok) begin
							fail = 1'b1;
						end else if (!last_dig) begin
							acc_d = acc_sh;
							cnt_d = cnt_q + 2'd1;
						end else begin
							acc_d = '0;
							cnt_d = '0;
							if (phase_q == PH_HEX1) begin
								if (is_high) begin
									hh_d    = acc_sh[9:0];
									phase_d = PH_WANT_BS;
								end else if (is_low) begin
									fail = 1'b1;
								end else begin
									phase_d = PH_STR;
								end
							end else if (is_low) begin
								phase_d = PH_STR;
								hh_d    = '0;
							end else begin
								fail = 1'b1;
							end
						end
					end
					default: begin
						// idle, only an opening quote is legal
						if (is_quote)
							phase_d = PH_STR;
						else
							fail = 1'b1;
					end
				endcase
			end
			if (fail) begin
				phase_d = PH_IDLE;
				acc_d   = '0;
				cnt_d   = '0;
				hh_d    = '0;
			end
		end
	end

	// command outputs
	always_comb begin
		cmd_push = 1'b0;
		cmd.kind = K_ERR;
		cmd.cp   = '0;
		if (accept) begin
			if (source_end) begin
				cmd_push = (phase_q != PH_IDLE);
			end else begin
				unique case (phase_q)
					PH_STR: begin
						if (is_quote) begin
							cmd_push = 1'b1;
							cmd.kind = K_DONE;
						end else if (is_ctrl) begin
							cmd_push = 1'b1;
						end else if (!is_bs) begin
							cmd_push = 1'b1;
							cmd.kind = K_RAW;
							cmd.cp   = {13'b0, in_byte};
						end
					end
					PH_ESC: begin
						if (esc[8]) begin
							cmd_push = 1'b1;
							cmd.kind = K_RAW;
							cmd.cp   = {13'b0, esc[7:0]};
						end else if (!is_u) begin
							cmd_push = 1'b1;
						end
					end
					PH_WANT_BS: cmd_push = !is_bs;
					PH_WANT_U:  cmd_push = !is_u;
					PH_HEX1: begin
						if (!hex_ok) begin
							cmd_push = 1'b1;
						end else if (last_dig && !is_high) begin
							cmd_push = 1'b1;
							if (!is_low) begin
								cmd.kind = K_CP;
								cmd.cp   = {5'b0, acc_sh};
							end
						end
					end
					PH_HEX2: begin
						if (!hex_ok) begin
							cmd_push = 1'b1;
						end else if (last_dig) begin
							cmd_push = 1'b1;
							if (is_low) begin
								cmd.kind = K_CP;
								cmd.cp   = supp_cp;
							end
						end
					end
					default: cmd_push = !is_quote;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			hh_q    <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			hh_q    <= hh_d;
		end
	end

endmodule

// ----- design/jsu_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// jsu_cmd_fifo
// short command queue between parser and byte emitter
// ----------------------------------------------------------------------------
module jsu_cmd_fifo #(
	parameter int Depth = jsu_pkg::JSU_CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  jsu_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output jsu_pkg::cmd_t rd_data,
	output logic          not_empty
);
	import jsu_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr, do_rd;

	assign full      = (cnt_q == FullCnt);
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
			if (do_rd)
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CntW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule

// ----- design/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// byte emitter: expands each command into one to four result bytes
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  jsu_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic [1:0]    outcome,
	output logic          last
);
	import jsu_pkg::*;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] oc_q;
	logic       last_q;
	logic [1:0] idx_q;

	logic       load;
	logic [1:0] lm1;
	logic [7:0] nbyte;
	logic [1:0] noc;
	logic       nlast;

	always_comb begin
		lm1   = 2'd0;
		nbyte = 8'h00;
		noc   = OC_BYTE;
		unique case (cmd.kind)
			K_RAW:  nbyte = cmd.cp[7:0];
			K_CP: begin
				lm1   = utf8_lm1(cmd.cp);
				nbyte = utf8_byte(cmd.cp, idx_q);
			end
			K_DONE: noc = OC_DONE;
			default: noc = OC_ERR;
		endcase
	end

	assign nlast   = (idx_q == lm1);
	assign load    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = load && nlast;

	assign empty    = !out_valid_q;
	assign out_byte = byte_q;
	assign outcome  = oc_q;
	assign last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nbyte;
			oc_q   <= noc;
			last_q <= nlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= nlast ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// decodes the bytes of a quoted json string literal into utf-8 output bytes
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: a request is taken on a clock edge with
//   push high and full low; in_byte carries the next source byte, source_end
//   marks the end of the source (byte ignored)
//   result side is a queue read port: while empty is low the oldest result
//   sits on out_byte / outcome / last and is taken on an edge with pop high
//   outcome: decoded byte, string complete or syntax error; last flags the
//   final result caused by one request
// timing
//   a result reaches the ports through the command queue write, then the output
//   register; further bytes follow one per cycle while pop is high
//   one request per cycle is sustained while pop is high; the output register
//   emits one byte per cycle, so a \u escape or surrogate pair that becomes
//   two to four utf-8 bytes holds the emitter until its last byte and the command queue absorbs the burst
// stalls and reset
//   with pop held low the output register and the command queue fill, then
//   full rises and the parser waits; nothing is lost
//   arst_n clears the parser to idle and empties queue and output register
// ----------------------------------------------------------------------------
module json_string_unescape #(
	parameter int CmdDepth = jsu_pkg::JSU_CMD_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       source_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [1:0] outcome,
	output logic       last
);
	import jsu_pkg::*;

	// front to queue
	cmd_t cmd_in;
	logic cmd_push;
	logic cmd_full;

	// queue to back
	cmd_t cmd_head;
	logic cmd_valid;
	logic cmd_pop;

	// input requests stall only on a full command queue
	assign full = cmd_full;

	// parser: classifies each source byte into at most one command
	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.source_end(source_end),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// decouples the parser from output stalls and multi-byte expansion
	jsu_cmd_fifo #(
		.Depth(CmdDepth)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_in),
		.full     (cmd_full),
		.rd_en    (cmd_pop),
		.rd_data  (cmd_head),
		.not_empty(cmd_valid)
	);

	// emitter: utf-8 encodes code points, one result byte per cycle while pop is high
	jsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.outcome  (outcome),
		.last     (last)
	);

	// checks
	`include "json_string_unescape_assert.svh"

	// the parser never issues a command into a full queue
	`JSU_ASSERT_IMP(a_no_push_when_full, cmd_push, !cmd_full)
	// completion and error results are always single
	`JSU_ASSERT_IMP(a_status_is_last, !empty && (outcome != OC_BYTE), last)
	// completion and error results carry a zero byte
	`JSU_ASSERT_IMP(a_status_zero_byte, !empty && (outcome != OC_BYTE), out_byte == 8'h00)
	// a queued command with a free output slot is taken on the next edge
	`JSU_ASSERT_NXT(a_back_drains, cmd_valid && empty, !empty)

endmodule
